### hw/rtl/humidity_temp_frame_decode_top_macros.svh
// Assertion macros for the humidity/temperature frame decoder checker.
// Used by htfd_checker.sv only; no other dependencies.
`ifndef HUMIDITY_TEMP_FRAME_DECODE_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODE_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define HTFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("htfd check failed");

// Next-cycle implication, ignored while reset is high.
`define HTFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("htfd check failed");

// Next-cycle implication that is also checked across reset.
`define HTFD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("htfd check failed");

`endif

### hw/rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package htfd_pkg;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_SEED    = 8'hFF;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUMI_SCALE  = 14'd10000;

   // One fully received frame, handed from the byte collector to scaling.
   typedef struct packed {
      logic [15:0] temp_raw;
      logic [15:0] humi_raw;
      logic        temp_ok;
      logic        humi_ok;
   } frame_type;

   // CRC-8, MSB first, one byte unrolled.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

endpackage

### hw/rtl/htfd_frame.sv
// Byte collector: tracks frame position, runs the CRC, holds one finished frame.
// Depends on htfd_pkg.
`timescale 1ns / 1ps

module htfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_frame_start,
   output logic                frm_valid,
   output htfd_pkg::frame_type frm,
   input  logic                frm_take_ok
);

   typedef enum logic [2:0] {
      POS_T_HI, POS_T_LO, POS_T_CRC, POS_H_HI, POS_H_LO, POS_H_CRC
   } pos_type;

   pos_type             pos_ff, pos_in, eff_pos;
   logic [7:0]          crc_ff, crc_in;
   logic [15:0]         temp_raw_ff, temp_raw_in;
   logic [15:0]         humi_raw_ff, humi_raw_in;
   logic                temp_pass_ff, temp_pass_in;
   logic                frm_valid_ff, frm_valid_in;
   htfd_pkg::frame_type frm_ff, frm_in;
   logic                accept, produce, take;
   logic [7:0]          crc_step;

   assign take      = frm_valid_ff & frm_take_ok;
   assign req_stall = frm_valid_ff & ~frm_take_ok;
   assign accept    = req_valid & ~req_stall;

   assign eff_pos  = req_frame_start ? POS_T_HI : pos_ff;
   // A word's first byte starts from the seed.
   assign crc_step = htfd_pkg::crc8_byte(
      (eff_pos == POS_T_HI || eff_pos == POS_H_HI) ? htfd_pkg::CRC_SEED : crc_ff,
      req_data_byte);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_raw_in  = temp_raw_ff;
      humi_raw_in  = humi_raw_ff;
      temp_pass_in = temp_pass_ff;
      produce      = 1'b0;
      frm_in       = frm_ff;
      // Bytes outside a frame (no start marker while waiting) are dropped.
      if (accept && (req_frame_start || pos_ff != POS_T_HI)) begin
         unique case (eff_pos)
            POS_T_HI: begin
               temp_raw_in = {req_data_byte, 8'h00};
               crc_in      = crc_step;
               pos_in      = POS_T_LO;
            end
            POS_T_LO: begin
               temp_raw_in = {temp_raw_ff[15:8], req_data_byte};
               crc_in      = crc_step;
               pos_in      = POS_T_CRC;
            end
            POS_T_CRC: begin
               temp_pass_in = (crc_ff == req_data_byte);
               crc_in       = htfd_pkg::CRC_SEED;
               pos_in       = POS_H_HI;
            end
            POS_H_HI: begin
               humi_raw_in = {req_data_byte, 8'h00};
               crc_in      = crc_step;
               pos_in      = POS_H_LO;
            end
            POS_H_LO: begin
               humi_raw_in = {humi_raw_ff[15:8], req_data_byte};
               crc_in      = crc_step;
               pos_in      = POS_H_CRC;
            end
            POS_H_CRC: begin
               crc_in          = htfd_pkg::CRC_SEED;
               pos_in          = POS_T_HI;
               produce         = 1'b1;
               frm_in.temp_raw = temp_raw_ff;
               frm_in.humi_raw = humi_raw_ff;
               frm_in.temp_ok  = temp_pass_ff;
               frm_in.humi_ok  = (crc_ff == req_data_byte);
            end
         endcase
      end
      frm_valid_in = produce | (frm_valid_ff & ~take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_T_HI;
         crc_ff       <= htfd_pkg::CRC_SEED;
         frm_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         frm_valid_ff <= frm_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_raw_ff  <= temp_raw_in;
      humi_raw_ff  <= humi_raw_in;
      temp_pass_ff <= temp_pass_in;
      frm_ff       <= frm_in;
   end

   assign frm_valid = frm_valid_ff;
   assign frm       = frm_ff;

endmodule

### hw/rtl/htfd_scale.sv
// Scaling stage: raw words to centi-units, flags, and the result register.
// Depends on htfd_pkg.
`timescale 1ns / 1ps

module htfd_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                frm_valid,
   input  htfd_pkg::frame_type frm,
   output logic                frm_take_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [14:0]  rsp_temperature_centi,
   output logic [13:0]         rsp_humidity_centi,
   output logic                rsp_temp_crc_ok,
   output logic                rsp_humi_crc_ok,
   output logic                rsp_frame_ok
);

   // floor(x / 65535), exact while the quotient stays below 65536.
   function automatic logic [15:0] div65535(input logic [31:0] x);
      logic [31:0] s;
      s = x + {16'h0000, x[31:16]} + 32'd1;
      return s[31:16];
   endfunction

   logic        rsp_valid_ff, rsp_valid_in;
   logic [14:0] temp_ff, temp_in;
   logic [13:0] humi_ff, humi_in;
   logic        temp_ok_ff, humi_ok_ff, frame_ok_ff;
   logic [31:0] temp_prod, humi_prod;
   logic [15:0] temp_q, humi_q;
   logic        load;

   assign frm_take_ok = ~rsp_valid_ff | ~rsp_stall;
   assign load        = frm_valid & frm_take_ok;

   assign temp_prod = 32'(frm.temp_raw) * 32'(htfd_pkg::TEMP_SCALE);
   assign humi_prod = 32'(frm.humi_raw) * 32'(htfd_pkg::HUMI_SCALE);
   assign temp_q    = div65535(temp_prod);
   assign humi_q    = div65535(humi_prod);
   assign temp_in   = temp_q[14:0] - htfd_pkg::TEMP_OFFSET;
   assign humi_in   = humi_q[13:0];

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         temp_ff     <= temp_in;
         humi_ff     <= humi_in;
         temp_ok_ff  <= frm.temp_ok;
         humi_ok_ff  <= frm.humi_ok;
         frame_ok_ff <= frm.temp_ok & frm.humi_ok;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = $signed(temp_ff);
   assign rsp_humidity_centi    = humi_ff;
   assign rsp_temp_crc_ok       = temp_ok_ff;
   assign rsp_humi_crc_ok       = humi_ok_ff;
   assign rsp_frame_ok          = frame_ok_ff;

endmodule

### hw/rtl/humidity_temp_frame_decode_top.sv
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_frame and htfd_scale.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data_byte, req_frame_start
//   rsp     | out       | rsp_valid/rsp_stall  | temperature, humidity, crc flags
//
// One byte item is taken per cycle unless req_stall is high. A frame's sixth byte
// gives its result item via the frame register, then scaling into the result register.
// Reset (synchronous) waits for a frame start and empties both registers.
// A stalled result holds; req_stall rises only when both registers are full.
`timescale 1ns / 1ps

module humidity_temp_frame_decode_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic               rsp_temp_crc_ok,
   output logic               rsp_humi_crc_ok,
   output logic               rsp_frame_ok
);

   logic                frm_valid;
   logic                frm_take_ok;
   htfd_pkg::frame_type frm;

   htfd_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .frm_valid       (frm_valid),
      .frm             (frm),
      .frm_take_ok     (frm_take_ok)
   );

   htfd_scale u_scale (
      .clock                 (clock),
      .reset                 (reset),
      .frm_valid             (frm_valid),
      .frm                   (frm),
      .frm_take_ok           (frm_take_ok),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temp_crc_ok       (rsp_temp_crc_ok),
      .rsp_humi_crc_ok       (rsp_humi_crc_ok),
      .rsp_frame_ok          (rsp_frame_ok)
   );

endmodule

### hw/rtl/htfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
// Depends on humidity_temp_frame_decode_top_macros.svh.
`timescale 1ns / 1ps
`include "humidity_temp_frame_decode_top_macros.svh"

module htfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [14:0] rsp_temperature_centi,
   input logic [13:0]        rsp_humidity_centi,
   input logic               rsp_temp_crc_ok,
   input logic               rsp_humi_crc_ok,
   input logic               rsp_frame_ok
);

   logic [31:0] rsp_bundle;
   logic        temp_in_range;

   // Whole result payload, so a stalled item is checked field by field at once.
   assign rsp_bundle = {rsp_temperature_centi, rsp_humidity_centi,
                        rsp_temp_crc_ok, rsp_humi_crc_ok, rsp_frame_ok};

   assign temp_in_range = (rsp_temperature_centi >= -15'sd4500) &&
                          (rsp_temperature_centi <= 15'sd13000);

   `HTFD_ASSERT_NEXT_ALWAYS(a_reset_empties, reset, !rsp_valid && !req_stall)

   `HTFD_ASSERT_NEXT(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bundle))

   `HTFD_ASSERT_NOW(a_frame_flag, rsp_valid, rsp_frame_ok == (rsp_temp_crc_ok && rsp_humi_crc_ok))

   `HTFD_ASSERT_NOW(a_humi_range, rsp_valid, rsp_humidity_centi <= 14'd10000)

   `HTFD_ASSERT_NOW(a_temp_range, rsp_valid, temp_in_range)

endmodule

bind humidity_temp_frame_decode_top htfd_checker u_htfd_checker (.*);
